/* sv/shabc_pkg.sv */
`timescale 1ns / 1ps
// shared types, codes, round constants and helper functions of the sha-256 compressor
package shabc_pkg;

  localparam int unsigned WordW   = 32;
  localparam int unsigned ChainN  = 8;
  localparam int unsigned WinN    = 16;
  localparam int unsigned RoundN  = 64;

  localparam logic [1:0] OP_WRITE_CHAIN = 2'd0;
  localparam logic [1:0] OP_MESSAGE     = 2'd1;
  localparam logic [1:0] OP_READ        = 2'd2;

  typedef logic [WordW-1:0] word_t;

  typedef struct packed {
    logic msg_shift;
    logic init;
    logic round;
  } shabc_ctrl_t;

  function automatic word_t rotr(input word_t x, input int unsigned n);
    rotr = (x >> n) | (x << (WordW - n));
  endfunction

  function automatic word_t big_sigma0(input word_t x);
    big_sigma0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic word_t big_sigma1(input word_t x);
    big_sigma1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic word_t small_sigma0(input word_t x);
    small_sigma0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic word_t small_sigma1(input word_t x);
    small_sigma1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

  function automatic word_t byte_reverse(input word_t x);
    byte_reverse = {x[7:0], x[15:8], x[23:16], x[31:24]};
  endfunction

  function automatic word_t round_k(input logic [5:0] i);
    word_t k;
    case (i)
      6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
      6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
      6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
      6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
      6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
      6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
      6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
      6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
      6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
      6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
      6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
      6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
      6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
      6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
      6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
      6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
      6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
      6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
      6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
      6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
      6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
      6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
      6'd62: k = 32'hbef9a3f7;  default: k = 32'hc67178f2;
    endcase
    round_k = k;
  endfunction

endpackage

/* sv/sha256_block_compressor_unit.sv */
`timescale 1ns / 1ps
// top level of the sha-256 compressor: sequencer, chaining words and readout
//
// channel   direction  transfer when         payload
// in_*      input      in_valid & !in_stall  operation, data_word, chain_index
// out_*     output     out_valid & !out_stall digest_word, digest_index, last_word
// cfg_*     input      cfg_wr_en             byte_swap
//
// chaining word writes and message words are taken only while the sequencer is idle
// the sixteenth message word starts the rounds in S_ROUND, followed by the add in S_FINAL
// a readout gives 8 transfers, each held back under out_stall
// rst_n clears chaining words, word count and sequencer and sets byte_swap
module sha256_block_compressor_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_operation,
  input  logic [31:0] in_data_word,
  input  logic [2:0]  in_chain_index,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_digest_word,
  output logic [2:0]  out_digest_index,
  output logic        out_last_word,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data
);

  typedef enum logic [1:0] {S_IDLE, S_ROUND, S_FINAL, S_READ} state_t;

  state_t                 state_r;
  logic                   byte_swap_r;
  logic [3:0]             word_cnt_r;
  logic [5:0]             round_r;
  logic                   out_valid_r;
  logic [2:0]             out_index_r;
  logic                   out_last_r;
  shabc_pkg::word_t       out_word_r;
  shabc_pkg::word_t       chain_r [shabc_pkg::ChainN];
  shabc_pkg::word_t       work    [shabc_pkg::ChainN];
  shabc_pkg::shabc_ctrl_t ctrl;
  shabc_pkg::word_t       msg_word;
  logic                   in_xfer;
  logic                   out_xfer;
  logic [2:0]             next_index;

  assign in_stall = (state_r != S_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign out_xfer = out_valid_r && !out_stall;
  assign msg_word = byte_swap_r ? shabc_pkg::byte_reverse(in_data_word) : in_data_word;
  assign next_index = out_index_r + 3'd1;

  always_comb begin
    ctrl.msg_shift = in_xfer && (in_operation == shabc_pkg::OP_MESSAGE);
    ctrl.init      = ctrl.msg_shift && (word_cnt_r == 4'd15);
    ctrl.round     = (state_r == S_ROUND);
  end

  shabc_core u_core (
    .clk      (clk),
    .ctrl     (ctrl),
    .msg_in   (msg_word),
    .k_in     (shabc_pkg::round_k(round_r)),
    .chain_in (chain_r),
    .work_out (work)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_swap_r <= 1'b1;
    end else if (cfg_wr_en) begin
      byte_swap_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      word_cnt_r  <= '0;
      round_r     <= '0;
      out_valid_r <= 1'b0;
      out_index_r <= '0;
      out_last_r  <= 1'b0;
      for (int i = 0; i < shabc_pkg::ChainN; i++) begin
        chain_r[i] <= '0;
      end
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_xfer) begin
            unique case (in_operation)
              shabc_pkg::OP_WRITE_CHAIN: begin
                chain_r[in_chain_index] <= in_data_word;
              end
              shabc_pkg::OP_MESSAGE: begin
                word_cnt_r <= word_cnt_r + 4'd1;
                if (word_cnt_r == 4'd15) begin
                  round_r <= '0;
                  state_r <= S_ROUND;
                end
              end
              shabc_pkg::OP_READ: begin
                out_valid_r <= 1'b1;
                out_index_r <= '0;
                out_last_r  <= 1'b0;
                out_word_r  <= chain_r[0];
                state_r     <= S_READ;
              end
              default: begin
              end
            endcase
          end
        end
        S_ROUND: begin
          round_r <= round_r + 6'd1;
          if (round_r == 6'd63) begin
            state_r <= S_FINAL;
          end
        end
        S_FINAL: begin
          for (int i = 0; i < shabc_pkg::ChainN; i++) begin
            chain_r[i] <= chain_r[i] + work[i];
          end
          state_r <= S_IDLE;
        end
        S_READ: begin
          if (out_xfer) begin
            if (out_last_r) begin
              out_valid_r <= 1'b0;
              state_r     <= S_IDLE;
            end else begin
              out_index_r <= next_index;
              out_last_r  <= (next_index == 3'd7);
              out_word_r  <= chain_r[next_index];
            end
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_digest_word  = out_word_r;
  assign out_digest_index = out_index_r;
  assign out_last_word    = out_last_r;

  a_no_input_during_readout: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> in_stall)
    else $error("input accepted during readout");

  a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_stall && out_last_r) |=> !out_valid_r)
    else $error("readout continues after last word");

  a_index_steps: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_stall && !out_last_r) |=>
      (out_valid_r && out_index_r == $past(out_index_r) + 3'd1))
    else $error("readout index did not advance");

  a_last_on_seven: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_last_r == (out_index_r == 3'd7)))
    else $error("last mark out of place");

endmodule

/* sv/shabc_core.sv */
`timescale 1ns / 1ps
// message window with on-the-fly schedule expansion and the shared round datapath
module shabc_core (
  input  logic                 clk,
  input  shabc_pkg::shabc_ctrl_t ctrl,
  input  shabc_pkg::word_t     msg_in,
  input  shabc_pkg::word_t     k_in,
  input  shabc_pkg::word_t     chain_in [shabc_pkg::ChainN],
  output shabc_pkg::word_t     work_out [shabc_pkg::ChainN]
);

  shabc_pkg::word_t w_r [shabc_pkg::WinN];
  shabc_pkg::word_t v_r [shabc_pkg::ChainN];
  shabc_pkg::word_t w_new;
  shabc_pkg::word_t t1;
  shabc_pkg::word_t t2;
  shabc_pkg::word_t ch;
  shabc_pkg::word_t maj;

  always_comb begin
    w_new = shabc_pkg::small_sigma1(w_r[14]) + w_r[9]
          + shabc_pkg::small_sigma0(w_r[1]) + w_r[0];
    ch    = (v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]);
    maj   = (v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]);
    t1    = v_r[7] + shabc_pkg::big_sigma1(v_r[4]) + ch + k_in + w_r[0];
    t2    = shabc_pkg::big_sigma0(v_r[0]) + maj;
  end

  always_ff @(posedge clk) begin
    if (ctrl.msg_shift || ctrl.round) begin
      for (int i = 0; i < shabc_pkg::WinN - 1; i++) begin
        w_r[i] <= w_r[i+1];
      end
      w_r[shabc_pkg::WinN-1] <= ctrl.round ? w_new : msg_in;
    end
    if (ctrl.init) begin
      for (int i = 0; i < shabc_pkg::ChainN; i++) begin
        v_r[i] <= chain_in[i];
      end
    end else if (ctrl.round) begin
      v_r[7] <= v_r[6];
      v_r[6] <= v_r[5];
      v_r[5] <= v_r[4];
      v_r[4] <= v_r[3] + t1;
      v_r[3] <= v_r[2];
      v_r[2] <= v_r[1];
      v_r[1] <= v_r[0];
      v_r[0] <= t1 + t2;
    end
  end

  assign work_out = v_r;

endmodule

/* bench/sha256_digest_checker.sv */
`timescale 1ns / 1ps
// checker for the sha-256 compressor: tracks chaining words, predicts readouts, compares
module sha256_digest_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [1:0]  in_operation,
  input  logic [31:0] in_data_word,
  input  logic [2:0]  in_chain_index,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [31:0] out_digest_word,
  input  logic [2:0]  out_digest_index,
  input  logic        out_last_word,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,
  output int          fail_count,
  output int          digests_pending
);

  localparam logic [64*32-1:0] ROUND_CONSTS = {
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  typedef struct packed {
    shabc_pkg::word_t word;
    logic [2:0]       index;
    logic             last;
  } digest_beat_t;

  shabc_pkg::word_t chain_state [8];
  shabc_pkg::word_t block_words [16];
  logic [3:0]       block_fill;
  logic             swap_en;
  digest_beat_t     digest_q [$];

  initial begin
    fail_count      = 0;
    digests_pending = 0;
  end

  function automatic shabc_pkg::word_t ror32(input shabc_pkg::word_t x, input int n);
    logic [63:0] dbl;
    dbl = {x, x} >> n;
    return dbl[31:0];
  endfunction

  function automatic void fold_block_into_chain();
    shabc_pkg::word_t sched [64];
    shabc_pkg::word_t v [8];
    shabc_pkg::word_t t1;
    shabc_pkg::word_t t2;
    for (int i = 0; i < 16; i++) sched[i] = block_words[i];
    for (int i = 16; i < 64; i++) begin
      sched[i] = (ror32(sched[i-2], 17) ^ ror32(sched[i-2], 19) ^ (sched[i-2] >> 10))
               + sched[i-7]
               + (ror32(sched[i-15], 7) ^ ror32(sched[i-15], 18) ^ (sched[i-15] >> 3))
               + sched[i-16];
    end
    for (int i = 0; i < 8; i++) v[i] = chain_state[i];
    for (int i = 0; i < 64; i++) begin
      t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6]))
         + ROUND_CONSTS[(63 - i) * 32 +: 32] + sched[i];
      t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6];
      v[6] = v[5];
      v[5] = v[4];
      v[4] = v[3] + t1;
      v[3] = v[2];
      v[2] = v[1];
      v[1] = v[0];
      v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) chain_state[i] = chain_state[i] + v[i];
  endfunction

  function automatic void apply_item(input logic [1:0] op, input shabc_pkg::word_t data,
                                     input logic [2:0] idx);
    digest_beat_t beat;
    case (op)
      shabc_pkg::OP_WRITE_CHAIN: chain_state[idx] = data;
      shabc_pkg::OP_MESSAGE: begin
        block_words[block_fill] = swap_en ? {data[7:0], data[15:8], data[23:16], data[31:24]}
                                          : data;
        block_fill = block_fill + 4'd1;
        if (block_fill == 4'd0) fold_block_into_chain();
      end
      shabc_pkg::OP_READ: begin
        for (int i = 0; i < 8; i++) begin
          beat.word  = chain_state[i];
          beat.index = i[2:0];
          beat.last  = (i == 7);
          digest_q.push_back(beat);
        end
      end
      default: ;
    endcase
  endfunction

  always @(posedge clk) begin
    digest_beat_t exp_beat;
    if (!rst_n) begin
      swap_en    = 1'b1;
      block_fill = 4'd0;
      for (int i = 0; i < 8; i++) chain_state[i] = '0;
      digest_q.delete();
      digests_pending = 0;
    end else begin
      if (cfg_wr_en) swap_en = cfg_wr_data;
      if (in_valid && !in_stall) apply_item(in_operation, in_data_word, in_chain_index);
      if (out_valid && !out_stall) begin
        if (digest_q.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected digest transfer, got word %h index %0d last %0d",
                   $time, out_digest_word, out_digest_index, out_last_word);
        end else begin
          exp_beat = digest_q.pop_front();
          if (out_digest_word !== exp_beat.word) begin
            fail_count++;
            $display("%0t: digest_word mismatch, expected %h, got %h",
                     $time, exp_beat.word, out_digest_word);
          end
          if (out_digest_index !== exp_beat.index) begin
            fail_count++;
            $display("%0t: digest_index mismatch, expected %0d, got %0d",
                     $time, exp_beat.index, out_digest_index);
          end
          if (out_last_word !== exp_beat.last) begin
            fail_count++;
            $display("%0t: last_word mismatch, expected %0d, got %0d",
                     $time, exp_beat.last, out_last_word);
          end
        end
      end
      digests_pending = digest_q.size();
    end
  end

endmodule

/* bench/sha256_block_compressor_unit_tb.sv */
`timescale 1ns / 1ps
// testbench top for the sha-256 compressor: clock, reset, stimulus, stall control and verdict
module sha256_block_compressor_unit_tb;

  localparam logic [1:0] OP_UNUSED    = 2'd3;
  localparam int         CYCLE_LIMIT  = 200000;
  localparam int         DRAIN_CYCLES = 80;
  localparam int         HOLD_CYCLES  = 400;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  in_operation;
  logic [31:0] in_data_word;
  logic [2:0]  in_chain_index;
  logic        out_valid;
  logic        out_stall;
  logic [31:0] out_digest_word;
  logic [2:0]  out_digest_index;
  logic        out_last_word;
  logic        cfg_wr_en;
  logic        cfg_wr_data;

  int   fail_count;
  int   digests_pending;
  int   idle_pct;
  int   stall_pct;
  int   items_sent;
  int   cycle_count;
  logic hold_req;

  sha256_block_compressor_unit DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_operation     (in_operation),
    .in_data_word     (in_data_word),
    .in_chain_index   (in_chain_index),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_digest_word  (out_digest_word),
    .out_digest_index (out_digest_index),
    .out_last_word    (out_last_word),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data)
  );

  sha256_digest_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_operation     (in_operation),
    .in_data_word     (in_data_word),
    .in_chain_index   (in_chain_index),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_digest_word  (out_digest_word),
    .out_digest_index (out_digest_index),
    .out_last_word    (out_last_word),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .fail_count       (fail_count),
    .digests_pending  (digests_pending)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("** sha256_block_compressor_unit: FAILED **");
      $finish;
    end
  end

  // result side: random stall, or a long hold-off on request
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_stall = 1'b1;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else begin
        out_stall = ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  function automatic shabc_pkg::word_t rand_word();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_item(input logic [1:0] op, input shabc_pkg::word_t data,
                           input logic [2:0] idx);
    logic taken;
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid       = 1'b1;
    in_operation   = op;
    in_data_word   = data;
    in_chain_index = idx;
    taken = 1'b0;
    while (!taken) begin
      @(posedge clk);
      taken = !in_stall;
    end
    @(negedge clk);
    if (op != OP_UNUSED) items_sent++;
  endtask

  task automatic send_read();
    send_item(shabc_pkg::OP_READ, rand_word(), 3'($urandom_range(0, 7)));
  endtask

  task automatic send_block();
    repeat (16) send_item(shabc_pkg::OP_MESSAGE, rand_word(), 3'($urandom_range(0, 7)));
  endtask

  task automatic load_chain();
    for (int i = 0; i < 8; i++) send_item(shabc_pkg::OP_WRITE_CHAIN, rand_word(), i[2:0]);
  endtask

  // register writes only once all readouts are in and any compression has drained
  task automatic set_byte_swap(input logic swap_on);
    in_valid = 1'b0;
    while (digests_pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    cfg_wr_en   = 1'b1;
    cfg_wr_data = swap_on;
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  task automatic run_phase(input int sender_pct, input int receiver_pct, input int n_items);
    int start;
    int pick;
    idle_pct  = sender_pct;
    stall_pct = receiver_pct;
    start     = items_sent;
    while (items_sent - start < n_items) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        send_block();
        if ($urandom_range(0, 1)) send_read();
      end else if (pick < 55) begin
        send_read();
      end else if (pick < 65) begin
        load_chain();
      end else if (pick < 75) begin
        send_item(shabc_pkg::OP_WRITE_CHAIN, rand_word(), 3'($urandom_range(0, 7)));
      end else if (pick < 85) begin
        repeat ($urandom_range(1, 15))
          send_item(shabc_pkg::OP_MESSAGE, rand_word(), 3'($urandom_range(0, 7)));
      end else if (pick < 92) begin
        send_item(OP_UNUSED, rand_word(), 3'($urandom_range(0, 7)));
      end else begin
        load_chain();
        send_block();
        send_read();
      end
    end
  endtask

  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_operation   = shabc_pkg::OP_WRITE_CHAIN;
    in_data_word   = '0;
    in_chain_index = '0;
    cfg_wr_en      = 1'b0;
    cfg_wr_data    = 1'b0;
    idle_pct       = 0;
    stall_pct      = 0;
    items_sent     = 0;
    hold_req       = 1'b0;
    repeat (7) @(negedge clk);
    rst_n = 1'b1;

    set_byte_swap(1'b1);
    send_item(shabc_pkg::OP_WRITE_CHAIN, 32'hffffffff, 3'd0);
    send_item(shabc_pkg::OP_WRITE_CHAIN, 32'h00000000, 3'd7);
    send_read();
    send_item(OP_UNUSED, 32'hffffffff, 3'd7);
    send_item(shabc_pkg::OP_MESSAGE, 32'hffffffff, 3'd7);
    send_item(shabc_pkg::OP_MESSAGE, 32'h00000000, 3'd0);
    send_item(shabc_pkg::OP_MESSAGE, 32'h12345678, 3'd5);
    send_item(shabc_pkg::OP_MESSAGE, 32'h80000000, 3'd2);
    send_item(shabc_pkg::OP_MESSAGE, 32'h00000001, 3'd4);
    // readout with a partial block pending, then a chaining word changed mid-block
    send_read();
    send_item(shabc_pkg::OP_WRITE_CHAIN, 32'h6a09e667, 3'd3);
    repeat (10) send_item(shabc_pkg::OP_MESSAGE, rand_word(), 3'($urandom_range(0, 7)));
    send_item(shabc_pkg::OP_MESSAGE, 32'hffffffff, 3'd1);
    send_read();

    set_byte_swap(1'b0);
    @(posedge clk);
    hold_req = 1'b1;
    @(posedge clk);
    hold_req = 1'b0;
    @(negedge clk);
    send_read();
    send_block();
    send_read();
    run_phase(0, 0, 30);

    set_byte_swap(1'b1);
    run_phase(54, 0, 70);
    set_byte_swap(1'b0);
    run_phase(0, 54, 70);
    set_byte_swap(1'b1);
    run_phase(26, 26, 70);

    in_valid = 1'b0;
    while (digests_pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0) begin
      $display("** sha256_block_compressor_unit: PASSED **");
    end else begin
      $display("** sha256_block_compressor_unit: FAILED **");
    end
    $finish;
  end

endmodule

/* sha256_block_compressor_unit.f */
sv/shabc_pkg.sv
sv/shabc_core.sv
sv/sha256_block_compressor_unit.sv
bench/sha256_digest_checker.sv
bench/sha256_block_compressor_unit_tb.sv
